>>> rtl/itt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_pkg
// Shared types and constants of the interval task timer table.
// ----------------------------------------------------------------------------
package itt_pkg;

	localparam int SLOTS      = 16;
	localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int TIME_W     = 32;
	localparam int SLOT_IDX_W = 4;
	localparam int MAX_OUT    = 16;
	localparam int REP_W      = $clog2(MAX_OUT + 1);

	// RAM word: {repeats, remaining count, interval, last fired}
	localparam int ENTRY_W    = 3 * TIME_W + 1;

	typedef enum logic [1:0] {
		KIND_ADD   = 2'd0,
		KIND_FIRED = 2'd1,
		KIND_IDLE  = 2'd2
	} result_kind_t;

	typedef struct packed {
		logic                  repeats;
		logic [TIME_W-1:0]     count;
		logic [TIME_W-1:0]     interval;
		logic [TIME_W-1:0]     last_fired;
	} entry_t;

endpackage

>>> rtl/itt_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_req_if
// Request channel: add a timer slot or run a tick scan.
// ----------------------------------------------------------------------------
interface itt_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [itt_pkg::TIME_W-1:0]  current_time;
	logic [itt_pkg::TIME_W-1:0]  interval;
	logic                        repeat_enable;
	logic [itt_pkg::TIME_W-1:0]  repeat_count;
	logic [itt_pkg::TIME_W-1:0]  start_shift;

	modport source (
		output valid, req_type, current_time, interval, repeat_enable,
		       repeat_count, start_shift,
		input  ready
	);
	modport sink (
		input  valid, req_type, current_time, interval, repeat_enable,
		       repeat_count, start_shift,
		output ready
	);
endinterface

>>> rtl/itt_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_res_if
// Result channel: add answers, fired slots and idle tick answers.
// ----------------------------------------------------------------------------
interface itt_res_if;
	logic                            valid;
	logic                            ready;
	itt_pkg::result_kind_t           result_kind;
	logic [itt_pkg::SLOT_IDX_W-1:0]  slot_index;
	logic                            table_full;
	logic                            slot_freed;
	logic                            last;

	modport source (
		output valid, result_kind, slot_index, table_full, slot_freed, last,
		input  ready
	);
	modport sink (
		input  valid, result_kind, slot_index, table_full, slot_freed, last,
		output ready
	);
endinterface

>>> rtl/itt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/interval_task_timer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_task_timer_table_unit
// Timer slot table: allocates slots on add, scans and fires slots on tick.
// ----------------------------------------------------------------------------
// Add: slots are probed in turn from slot 0 up to the first free one, then
//   the answer is posted (table_full if no slot is free).
// Tick: slot entries are read from one RAM port, one slot at a time; each slot
//   passes RD and EVAL, a fired slot also UPD, then ADV; results go via PUSH.
// Output stalls hold the unit in PUSH; ready returns when the last result loads.
// Reset clears the busy bits (all slots free) and the handshake state.
// ----------------------------------------------------------------------------
module interval_task_timer_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	itt_req_if.sink       req,
	itt_res_if.source     res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_RD,
		ST_EVAL,
		ST_UPD,
		ST_ADV,
		ST_PUSH
	} state_t;

	typedef struct packed {
		itt_pkg::result_kind_t           kind;
		logic [itt_pkg::SLOT_IDX_W-1:0]  idx;
		logic                            full;
		logic                            freed;
		logic                            last;
	} result_t;

	localparam logic [itt_pkg::IDX_W-1:0] LAST_IDX = itt_pkg::IDX_W'(itt_pkg::SLOTS - 1);
	localparam logic [itt_pkg::REP_W-1:0] REP_MAX  = itt_pkg::REP_W'(itt_pkg::MAX_OUT);

	state_t                          state_q;
	state_t                          ret_q;
	logic [itt_pkg::IDX_W-1:0]       idx_q;
	logic [itt_pkg::SLOTS-1:0]       busy_q;

	// captured request
	logic [itt_pkg::TIME_W-1:0]      now_q;
	logic [itt_pkg::TIME_W-1:0]      interval_q;
	logic                            repeat_q;
	logic [itt_pkg::TIME_W-1:0]      count_q;
	logic [itt_pkg::TIME_W-1:0]      shift_q;

	logic                            freed_q;
	logic                            pend_valid_q;
	logic [itt_pkg::IDX_W-1:0]       pend_idx_q;
	logic                            pend_freed_q;
	logic [itt_pkg::REP_W-1:0]       rep_cnt_q;

	result_t                         push_q;
	result_t                         out_q;
	logic                            out_valid_q;

	logic                            out_free;
	logic                            ram_we;
	logic                            ram_re;
	itt_pkg::entry_t                 ram_wdata;
	logic [itt_pkg::ENTRY_W-1:0]     ram_rdata;
	itt_pkg::entry_t                 rd_entry;
	logic [itt_pkg::TIME_W-1:0]      sub_a;
	logic [itt_pkg::TIME_W-1:0]      sub_b;
	logic [itt_pkg::TIME_W-1:0]      sub_y;
	logic [itt_pkg::TIME_W-1:0]      next_count;
	logic                            fire;

	assign rd_entry = itt_pkg::entry_t'(ram_rdata);
	assign out_free = !out_valid_q || res.ready;

	// shared subtractor: elapsed time in EVAL, count decrement in UPD
	always_comb begin
		sub_a = now_q;
		sub_b = rd_entry.last_fired;
		if (state_q == ST_UPD) begin
			sub_a = rd_entry.count;
			sub_b = itt_pkg::TIME_W'(1);
		end
	end
	assign sub_y = sub_a - sub_b;

	assign fire       = busy_q[idx_q] && (sub_y >= rd_entry.interval);
	assign next_count = (rd_entry.count == '0) ? '0 : sub_y;

	always_comb begin
		ram_re    = (state_q == ST_RD);
		ram_we    = 1'b0;
		ram_wdata = '{repeats: repeat_q, count: count_q, interval: interval_q,
		              last_fired: shift_q};
		if (state_q == ST_ADD) begin
			ram_we = !busy_q[idx_q];
		end else if (state_q == ST_UPD) begin
			ram_we    = !freed_q;
			ram_wdata = '{repeats: rd_entry.repeats, count: next_count,
			              interval: rd_entry.interval, last_fired: now_q};
		end
	end

	itt_ram #(
		.WIDTH (itt_pkg::ENTRY_W),
		.DEPTH (itt_pkg::SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ret_q        <= ST_IDLE;
			idx_q        <= '0;
			busy_q       <= '0;
			pend_valid_q <= 1'b0;
			rep_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// PUSH reloads the output register itself
			if (out_valid_q && res.ready && state_q != ST_PUSH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						now_q        <= req.current_time;
						interval_q   <= req.interval;
						repeat_q     <= req.repeat_enable;
						count_q      <= req.repeat_count;
						shift_q      <= req.start_shift;
						idx_q        <= '0;
						pend_valid_q <= 1'b0;
						rep_cnt_q    <= '0;
						state_q      <= req.req_type ? ST_RD : ST_ADD;
					end
				end
				ST_ADD: begin
					if (!busy_q[idx_q]) begin
						busy_q[idx_q] <= 1'b1;
						push_q  <= '{kind: itt_pkg::KIND_ADD,
						             idx: itt_pkg::SLOT_IDX_W'(idx_q),
						             full: 1'b0, freed: 1'b0, last: 1'b1};
						ret_q   <= ST_IDLE;
						state_q <= ST_PUSH;
					end else if (idx_q == LAST_IDX) begin
						push_q  <= '{kind: itt_pkg::KIND_ADD, idx: '0,
						             full: 1'b1, freed: 1'b0, last: 1'b1};
						ret_q   <= ST_IDLE;
						state_q <= ST_PUSH;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_RD: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					freed_q <= !rd_entry.repeats ||
					           (rd_entry.count == itt_pkg::TIME_W'(1));
					state_q <= fire ? ST_UPD : ST_ADV;
				end
				ST_UPD: begin
					if (freed_q) begin
						busy_q[idx_q] <= 1'b0;
					end
					// hold one fired result back so the final one can carry last
					if (rep_cnt_q < REP_MAX) begin
						rep_cnt_q    <= rep_cnt_q + 1'b1;
						pend_valid_q <= 1'b1;
						pend_idx_q   <= idx_q;
						pend_freed_q <= freed_q;
					end
					if (rep_cnt_q < REP_MAX && pend_valid_q) begin
						push_q  <= '{kind: itt_pkg::KIND_FIRED,
						             idx: itt_pkg::SLOT_IDX_W'(pend_idx_q),
						             full: 1'b0, freed: pend_freed_q,
						             last: 1'b0};
						ret_q   <= ST_ADV;
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (idx_q == LAST_IDX) begin
						if (pend_valid_q) begin
							push_q <= '{kind: itt_pkg::KIND_FIRED,
							            idx: itt_pkg::SLOT_IDX_W'(pend_idx_q),
							            full: 1'b0, freed: pend_freed_q,
							            last: 1'b1};
						end else begin
							push_q <= '{kind: itt_pkg::KIND_IDLE, idx: '0,
							            full: 1'b0, freed: 1'b0, last: 1'b1};
						end
						pend_valid_q <= 1'b0;
						ret_q        <= ST_IDLE;
						state_q      <= ST_PUSH;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_RD;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						out_q       <= push_q;
						out_valid_q <= 1'b1;
						state_q     <= ret_q;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready       = (state_q == ST_IDLE);
	assign res.valid       = out_valid_q;
	assign res.result_kind = out_q.kind;
	assign res.slot_index  = out_q.idx;
	assign res.table_full  = out_q.full;
	assign res.slot_freed  = out_q.freed;
	assign res.last        = out_q.last;

endmodule
